/* design/tll_pkg.sv */
// ----------------------------------------------------------------------------
// tll_pkg
// shared types and constants of the thermistor table linearizer
// ----------------------------------------------------------------------------
package tll_pkg;

	localparam int TABLE_ENTRIES_DEF = 32;

	localparam int IDX_W    = 5;
	localparam int VALUE_W  = 16;
	localparam int SAMPLE_W = 14;
	localparam int SCALE_W  = 8;
	localparam int TEMP_W   = 8;
	localparam int IN_DATA_W = 40;

	localparam logic [TEMP_W-1:0]  TOP_TEMPERATURE  = 8'd150;
	localparam logic [SCALE_W-1:0] STEP_SCALE_RESET = 8'd5;

	// request kinds carried on s_tuser
	localparam logic CMD_WRITE   = 1'b0;
	localparam logic CMD_CONVERT = 1'b1;

	typedef enum logic [2:0] {
		RD_FIRST,
		RD_LAST,
		RD_MID_INIT,
		RD_MID_NEXT,
		RD_SEG,
		RD_SEG_NEXT
	} rd_sel_t;

	typedef enum logic [1:0] {
		SEG_ZERO,
		SEG_LAST,
		SEG_MID,
		SEG_HI
	} seg_sel_t;

	typedef struct packed {
		logic     cap_in;
		logic     wr_en;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     bis_init;
		logic     bis_step;
		logic     seg_ld;
		seg_sel_t seg_sel;
		logic     cap_e;
		logic     cap_n;
		logic     prep;
		logic     div_init;
		logic     div_step;
		logic     out_ld;
		logic     out_top;
	} tll_cmd_t;

	typedef struct packed {
		logic t0_le_s;
		logic tl_ge_s;
		logic bis_eq;
		logic bis_hi_neg;
		logic bis_crossed;
		logic seg_last;
		logic div_last;
		logic out_free;
	} tll_stat_t;

endpackage

/* design/tll_ctrl.sv */
// ----------------------------------------------------------------------------
// tll_ctrl
// sequencer: table search, interpolation and divide steps
// ----------------------------------------------------------------------------
module tll_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_kind,
	output logic              in_ready,
	input  tll_pkg::tll_stat_t stat,
	output tll_pkg::tll_cmd_t  cmd
);

	typedef enum logic [11:0] {
		S_IDLE = 12'b0000_0000_0001,
		S_CHK0 = 12'b0000_0000_0010,
		S_CHKL = 12'b0000_0000_0100,
		S_BIS  = 12'b0000_0000_1000,
		S_RDE  = 12'b0000_0001_0000,
		S_RDN  = 12'b0000_0010_0000,
		S_CAPN = 12'b0000_0100_0000,
		S_PREP = 12'b0000_1000_0000,
		S_DIVI = 12'b0001_0000_0000,
		S_DIV  = 12'b0010_0000_0000,
		S_DONE = 12'b0100_0000_0000,
		S_TOP  = 12'b1000_0000_0000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap_in = 1'b1;
					if (in_kind == tll_pkg::CMD_WRITE) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = tll_pkg::RD_FIRST;
						state_d    = S_CHK0;
					end
				end
			end
			S_CHK0: begin
				if (stat.t0_le_s) begin
					cmd.seg_ld  = 1'b1;
					cmd.seg_sel = tll_pkg::SEG_ZERO;
					state_d     = S_RDE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = tll_pkg::RD_LAST;
					state_d    = S_CHKL;
				end
			end
			S_CHKL: begin
				if (stat.tl_ge_s) begin
					state_d = S_TOP;
				end else begin
					cmd.bis_init = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = tll_pkg::RD_MID_INIT;
					state_d      = S_BIS;
				end
			end
			S_BIS: begin
				if (stat.bis_eq) begin
					cmd.seg_ld  = 1'b1;
					cmd.seg_sel = tll_pkg::SEG_MID;
					state_d     = S_RDE;
				end else if (stat.bis_hi_neg) begin
					cmd.seg_ld  = 1'b1;
					cmd.seg_sel = tll_pkg::SEG_ZERO;
					state_d     = S_RDE;
				end else if (stat.bis_crossed) begin
					cmd.seg_ld  = 1'b1;
					cmd.seg_sel = tll_pkg::SEG_HI;
					state_d     = S_RDE;
				end else begin
					cmd.bis_step = 1'b1;
					cmd.rd_en    = 1'b1;
					cmd.rd_sel   = tll_pkg::RD_MID_NEXT;
				end
			end
			S_RDE: begin
				if (stat.seg_last) begin
					state_d = S_TOP;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = tll_pkg::RD_SEG;
					state_d    = S_RDN;
				end
			end
			S_RDN: begin
				cmd.cap_e  = 1'b1;
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = tll_pkg::RD_SEG_NEXT;
				state_d    = S_CAPN;
			end
			S_CAPN: begin
				cmd.cap_n = 1'b1;
				state_d   = S_PREP;
			end
			S_PREP: begin
				cmd.prep = 1'b1;
				state_d  = S_DIVI;
			end
			S_DIVI: begin
				cmd.div_init = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_TOP: begin
				if (stat.out_free) begin
					cmd.out_ld  = 1'b1;
					cmd.out_top = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

/* design/tll_dp.sv */
// ----------------------------------------------------------------------------
// tll_dp
// threshold table, bisection registers, multiplier, restoring divider
// and output register
// ----------------------------------------------------------------------------
module tll_dp #(
	parameter int TABLE_ENTRIES = tll_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tll_pkg::tll_cmd_t             cmd,
	output tll_pkg::tll_stat_t            stat,
	input  logic [tll_pkg::IN_DATA_W-1:0] in_data,
	input  logic                          cfg_we,
	input  logic [tll_pkg::SCALE_W-1:0]   cfg_wdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tll_pkg::TEMP_W-1:0]    out_temp,
	output logic                          out_flat
);

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 2);
	localparam logic [AW-1:0] MID_INIT = AW'((TABLE_ENTRIES - 2) / 2);
	localparam logic [6:0]    ENTRIES7 = 7'(TABLE_ENTRIES);

	localparam int VW = tll_pkg::VALUE_W;
	localparam int PW = tll_pkg::SCALE_W + VW;

	// request fields
	logic [tll_pkg::IDX_W-1:0]    in_idx;
	logic [VW-1:0]                in_value;
	logic [tll_pkg::SAMPLE_W-1:0] in_sample;
	logic [6:0]                   idx7;
	logic [AW-1:0]                waddr;
	logic                         idx_ok;

	assign in_idx    = in_data[4:0];
	assign in_value  = in_data[20:5];
	assign in_sample = in_data[34:21];
	assign idx7      = {2'b00, in_idx};
	assign waddr     = idx7[AW-1:0];
	assign idx_ok    = (idx7 < ENTRIES7);

	logic [VW-1:0] mem_q [TABLE_ENTRIES];
	logic [VW-1:0] rdata_q;
	logic [AW-1:0] raddr;

	logic [VW-1:0]              smp_q;
	logic [tll_pkg::SCALE_W-1:0] scale_q;
	logic [AW-1:0]              lo_q, hi_q, mid_q, seg_q;
	logic                       first_q;
	logic [VW-1:0]              e_q, n_q, dvs_q;
	logic [PW-1:0]              prod_q;
	logic                       flat_q, rise_q;
	logic [tll_pkg::TEMP_W-1:0] base_q;
	logic [VW-1:0]              rem_q;
	logic [7:0]                 dq_q;
	logic [2:0]                 cnt_q;
	logic                       out_valid_q;
	logic [tll_pkg::TEMP_W-1:0] out_temp_q;
	logic                       out_flat_q;

	// bisection step
	logic          gt, eq;
	logic [AW-1:0] lo_n, hi_n, mid_nx, seg_d;
	logic [AW:0]   mid_sum;

	assign eq      = (smp_q == rdata_q);
	assign gt      = (smp_q > rdata_q);
	assign lo_n    = (!gt && !first_q) ? (mid_q + AW'(1)) : lo_q;
	assign hi_n    = gt ? (mid_q - AW'(1)) : hi_q;
	assign mid_sum = {1'b0, lo_n} + {1'b0, hi_n};
	assign mid_nx  = mid_sum[AW:1];

	always_comb begin
		case (cmd.rd_sel)
			tll_pkg::RD_FIRST:    raddr = '0;
			tll_pkg::RD_LAST:     raddr = LAST_IDX;
			tll_pkg::RD_MID_INIT: raddr = MID_INIT;
			tll_pkg::RD_MID_NEXT: raddr = mid_nx;
			tll_pkg::RD_SEG:      raddr = seg_q;
			tll_pkg::RD_SEG_NEXT: raddr = seg_q + AW'(1);
			default:              raddr = '0;
		endcase
	end

	always_comb begin
		case (cmd.seg_sel)
			tll_pkg::SEG_ZERO: seg_d = '0;
			tll_pkg::SEG_LAST: seg_d = LAST_IDX;
			tll_pkg::SEG_MID:  seg_d = mid_q;
			tll_pkg::SEG_HI:   seg_d = hi_n;
			default:           seg_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en && idx_ok) begin
			mem_q[waddr] <= in_value;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem_q[raddr];
		end
	end

	// interpolation terms
	logic [VW-1:0]                 x_clamp, num;
	logic [PW-1:0]                 prod_d;
	logic [tll_pkg::SCALE_W+AW-1:0] base_prod;

	assign x_clamp   = (smp_q < e_q) ? smp_q : e_q;
	assign num       = (x_clamp >= n_q) ? (e_q - x_clamp) : (e_q - n_q);
	assign prod_d    = PW'(scale_q) * PW'(num);
	assign base_prod = (tll_pkg::SCALE_W+AW)'(scale_q) * (tll_pkg::SCALE_W+AW)'(seg_q);

	// restoring divide, one quotient bit a cycle
	logic [VW:0] trial;
	logic        ge;

	assign trial = {rem_q, dq_q[7]};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			smp_q <= VW'(in_sample);
		end
		if (cmd.bis_init) begin
			lo_q    <= '0;
			hi_q    <= LAST_IDX;
			mid_q   <= MID_INIT;
			first_q <= 1'b1;
		end else if (cmd.bis_step) begin
			lo_q    <= lo_n;
			hi_q    <= hi_n;
			mid_q   <= mid_nx;
			first_q <= 1'b0;
		end
		if (cmd.seg_ld) begin
			seg_q <= seg_d;
		end
		if (cmd.cap_e) begin
			e_q <= rdata_q;
		end
		if (cmd.cap_n) begin
			n_q <= rdata_q;
		end
		if (cmd.prep) begin
			prod_q <= prod_d;
			dvs_q  <= e_q - n_q;
			flat_q <= (e_q == n_q);
			rise_q <= (e_q < n_q);
			base_q <= base_prod[tll_pkg::TEMP_W-1:0];
		end
		if (cmd.div_init) begin
			rem_q <= prod_q[PW-1:8];
			dq_q  <= prod_q[7:0];
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
			dq_q  <= {dq_q[6:0], ge};
			cnt_q <= cnt_q + 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= tll_pkg::STEP_SCALE_RESET;
		end else if (cfg_we) begin
			scale_q <= cfg_wdata;
		end
	end

	// output register
	logic [tll_pkg::TEMP_W-1:0] frac;

	always_comb begin
		if (flat_q) begin
			frac = '0;
		end else if (rise_q) begin
			frac = scale_q;
		end else begin
			frac = dq_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			out_temp_q <= cmd.out_top ? tll_pkg::TOP_TEMPERATURE : (base_q + frac);
			out_flat_q <= cmd.out_top ? 1'b0 : flat_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_temp  = out_temp_q;
	assign out_flat  = out_flat_q;

	assign stat.t0_le_s     = (rdata_q <= smp_q);
	assign stat.tl_ge_s     = (rdata_q >= smp_q);
	assign stat.bis_eq      = eq;
	assign stat.bis_hi_neg  = gt && (mid_q == '0);
	assign stat.bis_crossed = (lo_n > hi_n);
	assign stat.seg_last    = (seg_q == LAST_IDX);
	assign stat.div_last    = (cnt_q == 3'd7);
	assign stat.out_free    = !out_valid_q || out_ready;

endmodule

/* design/thermistor_lut_linearizer_unit.sv */
// ----------------------------------------------------------------------------
// thermistor_lut_linearizer_unit
// thermistor sample to temperature by search and interpolation in a loaded table
// ----------------------------------------------------------------------------
// table write request: the next request may follow at once
// convert request: one table read per search step (up to 6) plus 8 divide steps
// the next request is taken in the cycle after the result is loaded; a result still
//   waiting in the output register holds a finished convert back
// arst_n clears the sequencer and output valid, sets step_scale to 5; table not cleared
module thermistor_lut_linearizer_unit #(
	parameter int TABLE_ENTRIES = tll_pkg::TABLE_ENTRIES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// entry_index[4:0], entry_value[20:5], sample[34:21], zero [39:35]
	input  logic [tll_pkg::IN_DATA_W-1:0] s_tdata,
	// cmd[0]
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// temperature[7:0]
	output logic [tll_pkg::TEMP_W-1:0]    m_tdata,
	// flat_segment[0]
	output logic                          m_tuser,
	input  logic                          cfg_we,
	input  logic [tll_pkg::SCALE_W-1:0]   cfg_wdata
);

	tll_pkg::tll_cmd_t  cmd;
	tll_pkg::tll_stat_t stat;

	tll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_kind  (s_tuser),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tll_dp #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_temp  (m_tdata),
		.out_flat  (m_tuser)
	);

`ifndef SYNTHESIS
	// result only written into a free output slot
	a_out_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!m_tvalid || m_tready))
		else $error("result loaded over a pending result");

	// a convert request keeps the block busy on the next cycle
	a_convert_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == tll_pkg::CMD_CONVERT) |=> !s_tready)
		else $error("convert request did not start the sequencer");

	// a table write finishes in its own cycle
	a_write_single: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == tll_pkg::CMD_WRITE) |=> s_tready)
		else $error("table write held the sequencer");

	// table written only by an accepted write request
	a_write_origin: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (s_tvalid && s_tready && s_tuser == tll_pkg::CMD_WRITE))
		else $error("table write without a write request");
`endif

endmodule

/* tb/thermistor_lut_linearizer_unit_tb.sv */
// ----------------------------------------------------------------------------
// thermistor_lut_linearizer_unit_tb
// loads threshold tables, converts samples under several step scales and
// checks every temperature and flat flag against a cycle-free software copy
// ----------------------------------------------------------------------------
module thermistor_lut_linearizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tll_pkg::*;

	localparam int ENTRIES       = TABLE_ENTRIES_DEF;
	localparam int LAST_SEG      = ENTRIES - 2;
	localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
	localparam int IDLE_PCT      = 8;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 3000;
	localparam int PHASE_ITEMS   = 85;

	typedef struct {
		logic               cmd;
		logic [IDX_W-1:0]   idx;
		logic [VALUE_W-1:0] value;
		logic [SAMPLE_W-1:0] sample;
	} request_t;

	typedef struct {
		logic [TEMP_W-1:0] temperature;
		logic              flat;
	} reading_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TEMP_W-1:0]    m_tdata;
	logic                 m_tuser;
	logic                 cfg_we = 1'b0;
	logic [SCALE_W-1:0]   cfg_wdata = '0;

	request_t       pending_q[$];
	reading_t       temp_due_q[$];
	logic [VALUE_W-1:0] lut_model[ENTRIES];
	logic [VALUE_W-1:0] lut_plan[ENTRIES];
	logic [SCALE_W-1:0] scale_model = STEP_SCALE_RESET;
	int             errors = 0;
	int             stall_cycles = 0;
	int             hold_left = 0;
	bit             req_taken = 1'b0;
	bit             steady = 1'b0;
	bit             hold_arm = 1'b0;

	thermistor_lut_linearizer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #2 clk = ~clk;

	// bisection exactly as the block does it, also for unordered tables
	function automatic int locate_segment(logic [SAMPLE_W-1:0] s);
		int lo;
		int hi;
		int mid;
		int sv;
		int mv;
		sv = {18'd0, s};
		if ({16'd0, lut_model[0]} <= sv) return 0;
		if ({16'd0, lut_model[LAST_SEG]} >= sv) return LAST_SEG;
		lo = 0;
		hi = LAST_SEG;
		mid = hi >> 1;
		mv = {16'd0, lut_model[mid]};
		if (sv == mv) return mid;
		forever begin
			if (sv > mv) hi = mid - 1;
			if (hi < 0) return 0;
			if (lo > hi) return hi;
			mid = (lo + hi) >> 1;
			mv = {16'd0, lut_model[mid]};
			if (sv == mv) return mid;
			if (sv < mv) lo = mid + 1;
		end
	endfunction

	function automatic reading_t predict_reading(logic [SAMPLE_W-1:0] s);
		reading_t r;
		int seg;
		int e;
		int n;
		int x;
		int num;
		int dv;
		int sc;
		int acc;
		seg = locate_segment(s);
		r.flat = 1'b0;
		if (seg >= LAST_SEG) begin
			r.temperature = TOP_TEMPERATURE;
			return r;
		end
		e = {16'd0, lut_model[seg]};
		n = {16'd0, lut_model[seg + 1]};
		x = {18'd0, s};
		if (x >= e) x = e;
		num = (x >= n) ? (e - x) : (e - n);
		dv = e - n;
		sc = {24'd0, scale_model};
		acc = sc * seg;
		// equal ends: no fraction, only the segment base
		if (dv == 0) begin
			r.flat = 1'b1;
		end else begin
			acc = acc + (sc * num) / dv;
		end
		r.temperature = acc[TEMP_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	// input side: model update or prediction on every accepted request
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) scale_model = cfg_wdata;
			if (s_tvalid && s_tready) begin
				req_taken = 1'b1;
				if (s_tuser == CMD_WRITE) begin
					lut_model[s_tdata[IDX_W-1:0]] = s_tdata[IDX_W +: VALUE_W];
				end else begin
					temp_due_q.push_back(predict_reading(s_tdata[IDX_W+VALUE_W +: SAMPLE_W]));
				end
			end
		end
	end

	// output side
	always @(posedge clk) begin : result_check
		reading_t due;
		if (arst_n && m_tvalid && m_tready) begin
			if (temp_due_q.size() == 0) begin
				report_mismatch($sformatf("result %0d with none pending", m_tdata));
			end else begin
				due = temp_due_q.pop_front();
				if (m_tdata !== due.temperature)
					report_mismatch($sformatf("temperature %0d, want %0d",
						m_tdata, due.temperature));
				if (m_tuser !== due.flat)
					report_mismatch($sformatf("flat_segment %b, want %b", m_tuser, due.flat));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				stall_cycles = 0;
			end else begin
				stall_cycles++;
				if (stall_cycles >= STALL_LIMIT) begin
					$display("timeout after %0d idle cycles", stall_cycles);
					$display("thermistor_lut_linearizer_unit_tb failed");
					$finish;
				end
			end
		end
	end

	always @(negedge clk) begin : request_driver
		request_t r;
		if (arst_n && (!s_tvalid || req_taken)) begin
			if (pending_q.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				r = pending_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser  <= r.cmd;
				s_tdata  <= {5'd0, r.sample, r.value, r.idx};
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	always @(negedge clk) begin
		// one long hold-off so the block backs up into the input side
		if (hold_arm) begin
			hold_arm = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= arst_n && (steady || $urandom_range(99) >= IDLE_PCT);
		end
	end

	task automatic queue_write(int idx, int value);
		request_t r;
		r.cmd = CMD_WRITE;
		r.idx = idx[IDX_W-1:0];
		r.value = value[VALUE_W-1:0];
		r.sample = SAMPLE_W'($urandom_range(SAMPLE_MAX));
		lut_plan[idx] = r.value;
		pending_q.push_back(r);
	endtask

	task automatic queue_convert(int sample);
		request_t r;
		r.cmd = CMD_CONVERT;
		r.idx = IDX_W'($urandom_range(ENTRIES - 1));
		r.value = VALUE_W'($urandom_range(16'hFFFF));
		r.sample = sample[SAMPLE_W-1:0];
		pending_q.push_back(r);
	endtask

	task automatic queue_descending_table();
		int v;
		v = $urandom_range(SAMPLE_MAX, 9000);
		for (int i = 0; i < ENTRIES; i++) begin
			queue_write(i, v);
			case ($urandom_range(19))
				0, 1:    v = v;
				2:       v = v + $urandom_range(500);
				default: v = v - $urandom_range(700, 1);
			endcase
			if (v < 0) v = 0;
			if (v > 16'hFFFF) v = 16'hFFFF;
		end
	endtask

	task automatic queue_phase(int count);
		int made;
		int k;
		int v;
		made = 0;
		if ($urandom_range(1)) begin
			queue_descending_table();
			made = ENTRIES;
		end
		while (made < count) begin
			k = $urandom_range(99);
			if (k < 15) begin
				v = $urandom_range(1) ? $urandom_range(16'hFFFF) : $urandom_range(SAMPLE_MAX);
				queue_write($urandom_range(ENTRIES - 1), v);
			end else begin
				if (k < 50) begin
					v = $urandom_range(SAMPLE_MAX);
				end else if (k < 75) begin
					v = lut_plan[$urandom_range(LAST_SEG)] + $urandom_range(4) - 2;
				end else if (k < 88) begin
					v = lut_plan[$urandom_range(LAST_SEG)];
				end else begin
					v = $urandom_range(1) ? SAMPLE_MAX : 0;
				end
				if (v < 0 || v > SAMPLE_MAX) v = $urandom_range(SAMPLE_MAX);
				queue_convert(v);
			end
			made++;
		end
	endtask

	task automatic settle();
		while (pending_q.size() != 0 || s_tvalid || temp_due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_scale(logic [SCALE_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : stimulus
		logic [SCALE_W-1:0] scales[6];
		scales = '{8'd0, 8'd255, 8'd1, 8'd128, 8'd0, 8'd0};
		scales[4] = SCALE_W'($urandom_range(254, 2));
		scales[5] = SCALE_W'($urandom_range(254, 2));
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset scale, evenly falling table with one flat pair
		queue_write(31, 16'hFFFF);
		queue_write(0, 16'hFFFF);
		for (int i = 0; i < ENTRIES - 1; i++) queue_write(i, 16000 - 520 * i);
		queue_write(8, 16000 - 520 * 7);
		queue_write(31, 0);
		queue_convert(SAMPLE_MAX);        // above the top entry
		queue_convert(0);                 // below the last segment
		queue_convert(16000);             // equal to the top entry
		queue_convert(15999);
		queue_convert(16000 - 520 * 15);  // hits the first middle probe
		queue_convert(16000 - 520 * 7);   // flat pair
		queue_convert(16000 - 520 * 3 - 260);
		queue_convert(16000 - 520 * 30);  // equal to the last searched entry
		queue_convert(16000 - 520 * 30 + 1);
		// rising segment in the middle of the table
		queue_write(10, SAMPLE_MAX);
		queue_convert(16000 - 520 * 9 - 1);
		queue_convert(16000 - 520 * 9 + 1);
		queue_convert(16000 - 520 * 11 + 3);
		queue_convert(SAMPLE_MAX - 1);
		// top entry out of sample reach
		queue_write(0, 16'hFFFF);
		queue_convert(SAMPLE_MAX);
		queue_convert(15000);
		queue_write(0, 16000);
		queue_write(10, 16000 - 520 * 10);

		for (int p = 0; p < 6; p++) begin
			settle();
			write_scale(scales[p]);
			steady = (p == 1);
			queue_phase(PHASE_ITEMS);
			if (p == 3) hold_arm = 1'b1;
		end
		settle();
		if (errors == 0) begin
			$display("thermistor_lut_linearizer_unit_tb passed");
		end else begin
			$display("thermistor_lut_linearizer_unit_tb failed");
		end
		$finish;
	end

endmodule
